@@ rtl/sctkf_pkg.sv @@
// Shared types, constants and character tables for the scan-code translator.
// Used by every module of the block but sctkf_ram; depends on nothing.
`timescale 1ns / 1ps

package sctkf_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int SCAN_W      = 7;
	localparam int CHAR_W      = 8;
	localparam int KEY_W       = SCAN_W + CHAR_W;
	localparam int FILL_W      = 5;

	// Scan-code set 1 bytes with a meaning of their own
	localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
	localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
	localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
	localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
	localparam int         SC_BREAK_BIT    = 7;

	// Character ROM
	localparam int ROM_SIZE  = 90;
	localparam int ROM_IDX_W = $clog2(ROM_SIZE);

	localparam logic [7:0] ROM_PLAIN [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'hFE, 8'h00, 8'h2D, 8'hFC, 8'h00, 8'hFD, 8'h2B, 8'h00,
		8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] ROM_SHIFT [ROM_SIZE] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'hFE, 8'h00, 8'h2D, 8'hFC, 8'h00, 8'hFD, 8'h2B, 8'h00,
		8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_DROPPED = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// Request and response words
	typedef struct packed {
		logic       func;
		logic [7:0] scan_code;
	} req_t;

	typedef struct packed {
		status_t             status;
		logic [SCAN_W-1:0]   key_scan;
		logic [CHAR_W-1:0]   key_char;
		logic [FILL_W-1:0]   fill_level;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic take;      // request word accepted this cycle
		logic load_pop;  // RAM read data valid, load popped key into response
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic needs_pop; // current request is a read of a non-empty queue
	} dp_stat_t;

	// Character lookup: codes past the table give 0
	function automatic logic [CHAR_W-1:0] lookup_char(input logic [7:0] code,
	                                                  input logic       shift);
		logic [ROM_IDX_W-1:0] idx;
		idx = code[ROM_IDX_W-1:0];
		if (code >= 8'(ROM_SIZE)) begin
			return '0;
		end else if (shift) begin
			return ROM_SHIFT[idx];
		end else begin
			return ROM_PLAIN[idx];
		end
	endfunction

endpackage

@@ rtl/sctkf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module sctkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/sctkf_dp.sv @@
// Datapath: shift flag, queue pointers and count, key RAM, response register.
// Depends on sctkf_pkg and sctkf_ram.
`timescale 1ns / 1ps

module sctkf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sctkf_pkg::req_t   req,
	input  sctkf_pkg::cmd_t   cmd,
	output sctkf_pkg::dp_stat_t stat,
	output sctkf_pkg::rsp_t   rsp
);

	logic                            shift_q;
	logic [sctkf_pkg::PTR_W-1:0]     wr_ptr_q;
	logic [sctkf_pkg::PTR_W-1:0]     rd_ptr_q;
	logic [sctkf_pkg::CNT_W-1:0]     count_q;
	sctkf_pkg::rsp_t                 rsp_q;

	logic                            is_read;
	logic                            is_shift_rel;
	logic                            is_break;
	logic                            is_shift_press;
	logic                            full;
	logic                            empty;
	logic                            store;
	logic                            pop;
	sctkf_pkg::status_t              res_status;
	logic [sctkf_pkg::CNT_W-1:0]     count_after;
	logic [sctkf_pkg::CHAR_W-1:0]    char_lu;
	logic [sctkf_pkg::KEY_W-1:0]     wdata;
	logic [sctkf_pkg::KEY_W-1:0]     rdata;

	// classify the incoming word
	assign is_read        = req.func;
	assign is_shift_rel   = (req.scan_code == sctkf_pkg::SC_LSHIFT_BREAK) ||
	                        (req.scan_code == sctkf_pkg::SC_RSHIFT_BREAK);
	assign is_break       = req.scan_code[sctkf_pkg::SC_BREAK_BIT];
	assign is_shift_press = (req.scan_code == sctkf_pkg::SC_LSHIFT_MAKE) ||
	                        (req.scan_code == sctkf_pkg::SC_RSHIFT_MAKE);
	assign full           = (count_q == sctkf_pkg::CNT_W'(sctkf_pkg::QUEUE_DEPTH));
	assign empty          = (count_q == '0);
	assign store          = !is_read && !is_break && !is_shift_press && !full;
	assign pop            = is_read && !empty;
	assign stat.needs_pop = pop;

	// status for words answered right away
	always_comb begin
		if (is_read) begin
			res_status = empty ? sctkf_pkg::ST_EMPTY : sctkf_pkg::ST_OK;
		end else if (is_break || is_shift_press) begin
			res_status = sctkf_pkg::ST_IGNORED;
		end else if (full) begin
			res_status = sctkf_pkg::ST_DROPPED;
		end else begin
			res_status = sctkf_pkg::ST_OK;
		end
	end

	assign count_after = store ? count_q + 1'b1 : count_q;

	// translate and pack the key entry
	assign char_lu = sctkf_pkg::lookup_char(req.scan_code, shift_q);
	assign wdata   = {req.scan_code[sctkf_pkg::SCAN_W-1:0], char_lu};

	sctkf_ram #(
		.WIDTH (sctkf_pkg::KEY_W),
		.DEPTH (sctkf_pkg::QUEUE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (cmd.take && store),
		.waddr (wr_ptr_q),
		.wdata (wdata),
		.re    (cmd.take && pop),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// control state: shift flag, pointers, count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q  <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (cmd.take) begin
			if (!is_read && is_shift_rel) begin
				shift_q <= 1'b0;
			end else if (!is_read && is_shift_press) begin
				shift_q <= 1'b1;
			end
			if (store) begin
				wr_ptr_q <= (wr_ptr_q == sctkf_pkg::PTR_W'(sctkf_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
				count_q  <= count_q + 1'b1;
			end else if (pop) begin
				rd_ptr_q <= (rd_ptr_q == sctkf_pkg::PTR_W'(sctkf_pkg::QUEUE_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
				count_q  <= count_q - 1'b1;
			end
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (cmd.load_pop) begin
			rsp_q.status     <= sctkf_pkg::ST_OK;
			rsp_q.key_scan   <= rdata[sctkf_pkg::KEY_W-1:sctkf_pkg::CHAR_W];
			rsp_q.key_char   <= rdata[sctkf_pkg::CHAR_W-1:0];
			rsp_q.fill_level <= sctkf_pkg::FILL_W'(count_q);
		end else if (cmd.take && !pop) begin
			rsp_q.status     <= res_status;
			rsp_q.key_scan   <= '0;
			rsp_q.key_char   <= '0;
			rsp_q.fill_level <= sctkf_pkg::FILL_W'(count_after);
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/sctkf_ctrl.sv @@
// Controller: handshakes on both channels and the pop sequence state machine.
// Depends on sctkf_pkg.
`timescale 1ns / 1ps

module sctkf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  sctkf_pkg::dp_stat_t stat,
	output sctkf_pkg::cmd_t     cmd
);

	typedef enum logic {
		S_IDLE,
		S_POP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   rsp_free;

	// response slot is free when empty or being drained this cycle
	assign rsp_free     = !rsp_valid_q || rsp_ready;
	assign req_ready    = (state_q == S_IDLE) && rsp_free;
	assign cmd.take     = req_valid && req_ready;
	assign cmd.load_pop = (state_q == S_POP);
	assign rsp_valid    = rsp_valid_q;

	// state and response valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.take && stat.needs_pop) begin
						state_q     <= S_POP;
						rsp_valid_q <= rsp_valid_q && !rsp_ready;
					end else if (cmd.take) begin
						rsp_valid_q <= 1'b1;
					end else if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				S_POP: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b1;
				end
				default: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ rtl/scancode_translator_key_fifo.sv @@
// Top level: scan-code set 1 translator with a key queue.
// Depends on sctkf_pkg, sctkf_ctrl, sctkf_dp (which holds sctkf_ram).
//
//   channel | dir | handshake             | word
//   --------+-----+-----------------------+-------------------------------------
//   req     | in  | req_valid / req_ready | func, scan_code
//   rsp     | out | rsp_valid / rsp_ready | status, key_scan, key_char, fill_level
//
// A scan-code word or a read of an empty queue has its response registered at the
// accepting edge. A popping read registers the key RAM read at that edge and loads
// the response from it in S_POP. The response register is shared, so req_ready
// drops while a response waits and rsp_ready is low. Reset clears the shift flag,
// pointers and count; the key RAM has no reset and needs no clear pass.
`timescale 1ns / 1ps

module scancode_translator_key_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  sctkf_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output sctkf_pkg::rsp_t rsp
);

	sctkf_pkg::cmd_t     cmd;
	sctkf_pkg::dp_stat_t stat;

	sctkf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	sctkf_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

@@ dv/scancode_translator_key_fifo_tb.sv @@
// Self-checking testbench for scancode_translator_key_fifo: drives scan-code and read words,
// predicts each response from a local model of the shift flag and key queue, and checks it.
// Depends on sctkf_pkg and the RTL of scancode_translator_key_fifo.
`timescale 1ns / 1ps

module scancode_translator_key_fifo_tb;

	localparam int          QDEPTH      = 16;
	localparam int          CHAR_CODES  = 90;
	localparam int          HOLD_CYCLES = 300;
	localparam int          STALL_LIMIT = 4000;
	localparam logic        FN_SCAN     = 1'b0;
	localparam logic        FN_READ     = 1'b1;

	// US layout, indexed by make code
	localparam logic [7:0] US_PLAIN [CHAR_CODES] = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'hFE, 8'h00, 8'h2D, 8'hFC, 8'h00, 8'hFD, 8'h2B, 8'h00,
		8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	localparam logic [7:0] US_SHIFTED [CHAR_CODES] = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
		8'h00, 8'h00, 8'hFE, 8'h00, 8'h2D, 8'hFC, 8'h00, 8'hFD, 8'h2B, 8'h00,
		8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
	};

	// Shadow of the shift flag and key queue; holds the responses still to come
	class keymap_scoreboard;
		bit                 shift_down;
		logic [14:0]        slots [QDEPTH];
		int unsigned        wr_ptr;
		int unsigned        rd_ptr;
		int unsigned        held;
		sctkf_pkg::rsp_t    awaited [$];
		int unsigned        errors;

		function new();
			shift_down = 1'b0;
			wr_ptr     = 0;
			rd_ptr     = 0;
			held       = 0;
			errors     = 0;
		endfunction

		// Predict the response to an accepted request word
		function void note_word(sctkf_pkg::req_t w);
			sctkf_pkg::rsp_t r;
			logic [7:0]      ch;
			r        = '0;
			r.status = sctkf_pkg::ST_OK;
			if (w.func == FN_READ) begin
				if (held == 0) begin
					r.status = sctkf_pkg::ST_EMPTY;
				end else begin
					r.key_scan = slots[rd_ptr][14:8];
					r.key_char = slots[rd_ptr][7:0];
					rd_ptr     = (rd_ptr + 1) % QDEPTH;
					held--;
				end
			end else if (w.scan_code == sctkf_pkg::SC_LSHIFT_BREAK ||
			             w.scan_code == sctkf_pkg::SC_RSHIFT_BREAK) begin
				shift_down = 1'b0;
				r.status   = sctkf_pkg::ST_IGNORED;
			end else if (w.scan_code[sctkf_pkg::SC_BREAK_BIT]) begin
				r.status = sctkf_pkg::ST_IGNORED;
			end else if (w.scan_code == sctkf_pkg::SC_LSHIFT_MAKE ||
			             w.scan_code == sctkf_pkg::SC_RSHIFT_MAKE) begin
				shift_down = 1'b1;
				r.status   = sctkf_pkg::ST_IGNORED;
			end else if (held >= QDEPTH) begin
				r.status = sctkf_pkg::ST_DROPPED;
			end else begin
				// codes past the table map to 0
				if (w.scan_code < CHAR_CODES)
					ch = shift_down ? US_SHIFTED[w.scan_code] : US_PLAIN[w.scan_code];
				else
					ch = 8'h00;
				slots[wr_ptr] = {w.scan_code[6:0], ch};
				wr_ptr        = (wr_ptr + 1) % QDEPTH;
				held++;
			end
			r.fill_level = 5'(held);
			awaited.push_back(r);
		endfunction

		// Compare an accepted response word with the oldest prediction
		function void check_word(sctkf_pkg::rsp_t got);
			sctkf_pkg::rsp_t want;
			if (awaited.size() == 0) begin
				$error("response word with nothing expected: %p", got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.key_scan !== want.key_scan) begin
				$error("key_scan: expected 0x%02h, got 0x%02h", want.key_scan, got.key_scan);
				errors++;
			end
			if (got.key_char !== want.key_char) begin
				$error("key_char: expected 0x%02h, got 0x%02h", want.key_char, got.key_char);
				errors++;
			end
			if (got.fill_level !== want.fill_level) begin
				$error("fill_level: expected %0d, got %0d", want.fill_level, got.fill_level);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	sctkf_pkg::req_t  req;
	logic             rsp_valid;
	logic             rsp_ready;
	sctkf_pkg::rsp_t  rsp;

	keymap_scoreboard sb;
	int unsigned      send_idle_pct;
	int unsigned      rsp_idle_pct;
	int unsigned      key_words_sent;
	bit               hold_rsp;

	scancode_translator_key_fifo uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Offer one request word, with random idle cycles ahead of it
	task automatic send_word(input sctkf_pkg::req_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			req       <= sctkf_pkg::req_t'($urandom);
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		key_words_sent++;
	endtask

	task automatic send_code(input logic [7:0] code);
		send_word({FN_SCAN, code});
	endtask

	task automatic send_read();
		send_word({FN_READ, 8'($urandom_range(255))});
	endtask

	// Stop offering and wait until every predicted response has come back
	task automatic wait_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0) @(posedge clk);
	endtask

	// Mostly real keys, a few codes past the table
	function automatic logic [7:0] pick_make();
		if ($urandom_range(99) < 85)
			return 8'($urandom_range(8'h59));
		return 8'($urandom_range(8'h7F, 8'h5A));
	endfunction

	// Keystrokes, fill bursts, read bursts and noise until the word count is reached
	task automatic run_random(input int unsigned upto);
		logic [7:0] code;
		bit         shifted;
		while (key_words_sent < upto) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					code    = pick_make();
					shifted = ($urandom_range(3) == 0);
					if (shifted)
						send_code($urandom_range(1) ? sctkf_pkg::SC_LSHIFT_MAKE :
						                              sctkf_pkg::SC_RSHIFT_MAKE);
					send_code(code);
					send_code(code | 8'h80);
					if (shifted && $urandom_range(7) != 0)
						send_code($urandom_range(1) ? sctkf_pkg::SC_LSHIFT_BREAK :
						                              sctkf_pkg::SC_RSHIFT_BREAK);
					if ($urandom_range(1))
						send_read();
				end
				6: begin
					repeat ($urandom_range(20, 12)) send_code(pick_make());
					repeat ($urandom_range(20, 8)) send_read();
				end
				7: repeat ($urandom_range(8, 1)) send_read();
				default: send_word(sctkf_pkg::req_t'($urandom));
			endcase
		end
	endtask

	// Response side: random back-pressure, or a long hold when asked
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	// Word monitor: note requests and check responses at the accepting edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_word(req);
			if (rsp_valid && rsp_ready)
				sb.check_word(rsp);
		end
	end

	// Watchdog on cycles with no word moving on either side
	initial begin
		int unsigned stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("scancode_translator_key_fifo verification failed");
		$finish;
	end

	initial begin
		sb             = new();
		arst_n         = 1'b0;
		req_valid      = 1'b0;
		req            = '0;
		hold_rsp       = 1'b0;
		key_words_sent = 0;
		send_idle_pct  = 17;
		rsp_idle_pct   = 51;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty read, shift press and release, arrows, break codes, edges of the table
		send_read();
		send_code(sctkf_pkg::SC_LSHIFT_MAKE);
		send_code(8'h02);
		send_code(8'h48);
		send_code(sctkf_pkg::SC_LSHIFT_BREAK);
		send_code(8'h02);
		send_code(sctkf_pkg::SC_RSHIFT_MAKE);
		send_code(8'h4B);
		send_code(sctkf_pkg::SC_RSHIFT_BREAK);
		send_code(8'hFF);
		send_code(8'h80);
		send_code(8'h00);
		send_code(8'h59);
		send_code(8'h5A);
		send_code(8'h7F);
		send_code(8'h4D);
		send_code(8'h50);
		repeat (10) send_read();
		wait_responses();

		// Random, sender lightly idle and receiver heavily stalled
		run_random(540);
		wait_responses();

		// Random, the other way round
		send_idle_pct = 51;
		rsp_idle_pct  = 17;
		run_random(1040);
		wait_responses();

		// Full rate, with one long receiver hold while keys are offered to fill the queue
		send_idle_pct = 0;
		rsp_idle_pct  = 0;
		hold_rsp      = 1'b1;
		repeat (20) send_code(pick_make());
		run_random(1550);
		wait_responses();
		repeat (4) @(posedge clk);

		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("scancode_translator_key_fifo verification clean");
		else
			$display("scancode_translator_key_fifo verification failed");
		$finish;
	end

endmodule
